// ===== rtl/fcsp_pkg.sv =====
// Shared types and constants for the framed command stream parser.
package fcsp_pkg;

    localparam int BYTE_W    = 8;
    localparam int KIND_W    = 2;
    localparam int INDEX_W   = 16;
    localparam int CFG_IDX_W = 2;

    typedef logic [BYTE_W-1:0]  t_byte;
    typedef logic [KIND_W-1:0]  t_kind;
    typedef logic [INDEX_W-1:0] t_index;

    localparam t_kind EV_PAYLOAD = 2'd0;
    localparam t_kind EV_ERROR   = 2'd1;
    localparam t_kind EV_END     = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_START     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_END       = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE    = 2'd3;

    localparam t_byte START_RST     = 8'd17;
    localparam t_byte SEPARATOR_RST = 8'd30;
    localparam t_byte END_RST       = 8'd4;
    localparam t_byte ESCAPE_RST    = 8'd16;

    typedef struct packed {
        t_byte start_byte;
        t_byte separator_byte;
        t_byte end_byte;
        t_byte escape_byte;
    } t_cfg;

endpackage

// ===== rtl/fcsp_ifs.sv =====
// Valid/ready channel interfaces for received bytes and parser events.
interface fcsp_rx_if;
    logic                          valid;
    logic                          ready;
    logic [fcsp_pkg::BYTE_W-1:0]   rx_byte;

    modport source(output valid, output rx_byte, input ready);
    modport sink(input valid, input rx_byte, output ready);
endinterface

interface fcsp_ev_if;
    logic                          valid;
    logic                          ready;
    logic [fcsp_pkg::KIND_W-1:0]   event_kind;
    logic [fcsp_pkg::BYTE_W-1:0]   op_code;
    logic [fcsp_pkg::BYTE_W-1:0]   param_id;
    logic [fcsp_pkg::BYTE_W-1:0]   param_size;
    logic [fcsp_pkg::INDEX_W-1:0]  byte_index;
    logic [fcsp_pkg::BYTE_W-1:0]   payload_byte;

    modport source(output valid, output event_kind, output op_code, output param_id,
                   output param_size, output byte_index, output payload_byte,
                   input ready);
    modport sink(input valid, input event_kind, input op_code, input param_id,
                 input param_size, input byte_index, input payload_byte,
                 output ready);
endinterface

// ===== rtl/framed_command_stream_parser_unit.sv =====
// Top level of the framed command stream parser.
// Takes one received byte per word on i_rx, one word per clock unless o_ev
// stalls; each word is held in the input register and its result in the event
// register until taken. Payload bytes come out as event_kind 0 with op_code,
// param_id, param_size and a 1-based 16-bit byte_index; a framing error (kind 1)
// and end of frame (kind 2) come out on the word after the one that caused them,
// with index and data zero. Words that cause no event are consumed silently. The
// user must set framing bytes through the write port (0 start, 1 separator, 2
// end, 3 escape) only while the parser is idle; the block does not enforce this.
module framed_command_stream_parser_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [fcsp_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [fcsp_pkg::BYTE_W-1:0]      i_cfg_wdata,
    fcsp_rx_if.sink                          i_rx,
    fcsp_ev_if.source                        o_ev
);
    import fcsp_pkg::*;

    t_cfg  w_cfg;
    logic  w_in_valid;
    t_byte w_in_byte;
    logic  w_take;

    fcsp_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_wdata (i_cfg_wdata),
        .o_cfg   (w_cfg)
    );

    fcsp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_take  (w_take),
        .o_valid (w_in_valid),
        .o_byte  (w_in_byte)
    );

    fcsp_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_valid (w_in_valid),
        .i_byte  (w_in_byte),
        .o_take  (w_take),
        .o_ev    (o_ev)
    );

endmodule

// ===== rtl/fcsp_cfg_regs.sv =====
// Framing byte configuration registers with write port.
module fcsp_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_we,
    input  logic [fcsp_pkg::CFG_IDX_W-1:0]   i_idx,
    input  logic [fcsp_pkg::BYTE_W-1:0]      i_wdata,
    output fcsp_pkg::t_cfg                   o_cfg
);
    import fcsp_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte     <= START_RST;
            r_cfg.separator_byte <= SEPARATOR_RST;
            r_cfg.end_byte       <= END_RST;
            r_cfg.escape_byte    <= ESCAPE_RST;
        end else if (i_we) begin
            case (i_idx)
                CFG_START:     r_cfg.start_byte     <= i_wdata;
                CFG_SEPARATOR: r_cfg.separator_byte <= i_wdata;
                CFG_END:       r_cfg.end_byte       <= i_wdata;
                CFG_ESCAPE:    r_cfg.escape_byte    <= i_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/fcsp_in_stage.sv =====
// Input register stage for received words.
module fcsp_in_stage (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    fcsp_rx_if.sink                       i_rx,
    input  logic                          i_take,
    output logic                          o_valid,
    output logic [fcsp_pkg::BYTE_W-1:0]   o_byte
);
    import fcsp_pkg::*;

    logic  r_valid;
    t_byte r_byte;
    logic  w_ready;

    assign w_ready    = !r_valid || i_take;
    assign i_rx.ready = w_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_rx.valid) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

// ===== rtl/fcsp_core.sv =====
// Framing state machine and event output register.
module fcsp_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  fcsp_pkg::t_cfg                i_cfg,
    input  logic                          i_valid,
    input  logic [fcsp_pkg::BYTE_W-1:0]   i_byte,
    output logic                          o_take,
    fcsp_ev_if.source                     o_ev
);
    import fcsp_pkg::*;

    typedef enum logic [2:0] {
        MODE_WAIT    = 3'd0,
        MODE_OP      = 3'd1,
        MODE_PARAM   = 3'd2,
        MODE_PAYLOAD = 3'd3,
        MODE_END     = 3'd4,
        MODE_ERROR   = 3'd5
    } t_mode;

    t_mode  r_mode,  n_mode;
    t_byte  r_op,    n_op;
    t_byte  r_param, n_param;
    t_byte  r_size,  n_size;
    t_index r_count, n_count;
    t_byte  r_prev,  n_prev;

    logic   r_out_valid;
    t_kind  r_out_kind,  n_out_kind;
    t_byte  r_out_op;
    t_byte  r_out_param;
    t_byte  r_out_size;
    t_index r_out_index, n_out_index;
    t_byte  r_out_data,  n_out_data;

    logic   w_take;
    logic   w_work;
    logic   w_emit;
    t_index w_size_ext;
    t_index w_count_inc;

    assign w_take      = !r_out_valid || o_ev.ready;
    assign w_work      = i_valid && w_take;
    assign o_take      = w_take;
    assign w_size_ext  = {{(INDEX_W-BYTE_W){1'b0}}, r_size};
    assign w_count_inc = r_count + 1'b1;

    always_comb begin
        n_mode      = r_mode;
        n_op        = r_op;
        n_param     = r_param;
        n_size      = r_size;
        n_count     = r_count;
        n_prev      = r_prev;
        w_emit      = 1'b0;
        n_out_kind  = EV_PAYLOAD;
        n_out_index = '0;
        n_out_data  = '0;
        if (w_work) begin
            n_prev = i_byte;
            case (r_mode)
                MODE_WAIT: begin
                    if (i_byte == i_cfg.start_byte) n_mode = MODE_OP;
                end
                MODE_OP: begin
                    n_op   = i_byte;
                    n_mode = MODE_PARAM;
                end
                MODE_PARAM: begin
                    if (r_prev == i_cfg.separator_byte && i_byte == i_cfg.end_byte) begin
                        n_mode = MODE_END;
                    end else if (r_param == r_prev) begin
                        n_size = i_byte;
                        n_mode = MODE_PAYLOAD;
                    end else begin
                        n_param = i_byte;
                    end
                end
                MODE_PAYLOAD: begin
                    if (r_prev == i_cfg.escape_byte && i_byte == i_cfg.separator_byte) begin
                        n_count = '0;
                        n_mode  = MODE_PARAM;
                    end else if (r_size != '0 && w_size_ext == r_count) begin
                        n_mode  = (i_byte == i_cfg.separator_byte) ? MODE_PARAM : MODE_ERROR;
                        n_count = '0;
                    end else begin
                        n_count = w_count_inc;
                        if (r_size == '0 || w_count_inc <= w_size_ext) begin
                            w_emit      = 1'b1;
                            n_out_kind  = EV_PAYLOAD;
                            n_out_index = w_count_inc;
                            n_out_data  = i_byte;
                        end
                    end
                end
                MODE_ERROR: begin
                    w_emit     = 1'b1;
                    n_out_kind = EV_ERROR;
                    n_mode     = MODE_END;
                end
                MODE_END: begin
                    w_emit     = 1'b1;
                    n_out_kind = EV_END;
                    n_op       = '0;
                    n_param    = '0;
                    n_size     = '0;
                    n_count    = '0;
                    n_mode     = MODE_WAIT;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_WAIT;
            r_op        <= '0;
            r_param     <= '0;
            r_size      <= '0;
            r_count     <= '0;
            r_prev      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_op    <= n_op;
            r_param <= n_param;
            r_size  <= n_size;
            r_count <= n_count;
            r_prev  <= n_prev;
            if (w_take) r_out_valid <= w_emit;
            if (w_emit) begin
                // event carries held values from before this word's update
                r_out_kind  <= n_out_kind;
                r_out_op    <= r_op;
                r_out_param <= r_param;
                r_out_size  <= r_size;
                r_out_index <= n_out_index;
                r_out_data  <= n_out_data;
            end
        end
    end

    assign o_ev.valid        = r_out_valid;
    assign o_ev.event_kind   = r_out_kind;
    assign o_ev.op_code      = r_out_op;
    assign o_ev.param_id     = r_out_param;
    assign o_ev.param_size   = r_out_size;
    assign o_ev.byte_index   = r_out_index;
    assign o_ev.payload_byte = r_out_data;

    a_wait_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == MODE_WAIT |-> r_op == '0 && r_param == '0 && r_size == '0 && r_count == '0)
        else $error("held frame state not cleared while waiting for start");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_size != '0 |-> r_count <= w_size_ext)
        else $error("payload count ran past declared size");

    a_error_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_work && r_mode == MODE_ERROR |=>
            r_out_valid && r_out_kind == EV_ERROR && r_mode == MODE_END)
        else $error("error mode did not produce error event");

    a_event_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_kind == EV_ERROR || r_out_kind == EV_END) |->
            r_out_index == '0 && r_out_data == '0)
        else $error("framing event carries payload data");

    a_sized_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_kind == EV_PAYLOAD && r_out_size != '0 |->
            r_out_index != '0 && r_out_index <= {{(INDEX_W-BYTE_W){1'b0}}, r_out_size})
        else $error("sized payload index out of range");

endmodule

// ===== dv/tb_framed_command_stream_parser_unit.sv =====
`timescale 1ns / 100ps
// Testbench for the framed command stream parser: byte streams checked against a framing tracker.

import fcsp_pkg::*;

typedef enum logic [2:0] {
    PM_WAIT,
    PM_OP,
    PM_PARAM,
    PM_PAYLOAD,
    PM_END,
    PM_ERROR
} t_parse_mode;

typedef struct packed {
    t_kind  kind;
    t_byte  op_code;
    t_byte  param_id;
    t_byte  param_size;
    t_index byte_index;
    t_byte  payload_byte;
} t_parser_event;

class frame_event_tracker;
    t_byte         start_b       = START_RST;
    t_byte         sep_b         = SEPARATOR_RST;
    t_byte         end_b         = END_RST;
    t_byte         esc_b         = ESCAPE_RST;
    t_parse_mode   parse_mode    = PM_WAIT;
    t_byte         held_op       = '0;
    t_byte         held_param    = '0;
    t_byte         held_size     = '0;
    t_index        payload_count = '0;
    t_byte         prev_b        = '0;
    t_parser_event due_events[$];
    int            errors        = 0;
    int            seen          = 0;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, t_byte value);
        case (idx)
            CFG_START:     start_b = value;
            CFG_SEPARATOR: sep_b   = value;
            CFG_END:       end_b   = value;
            CFG_ESCAPE:    esc_b   = value;
            default: ;
        endcase
    endfunction

    function int pending();
        return due_events.size();
    endfunction

    function void queue_event(t_kind kind, t_index index, t_byte data);
        t_parser_event ev;
        ev.kind         = kind;
        ev.op_code      = held_op;
        ev.param_id     = held_param;
        ev.param_size   = held_size;
        ev.byte_index   = index;
        ev.payload_byte = data;
        due_events.push_back(ev);
    endfunction

    // accepted input word
    function void take_byte(t_byte b);
        case (parse_mode)
            PM_WAIT: begin
                if (b == start_b) parse_mode = PM_OP;
            end
            PM_OP: begin
                held_op    = b;
                parse_mode = PM_PARAM;
            end
            PM_PARAM: begin
                if (prev_b == sep_b && b == end_b) begin
                    parse_mode = PM_END;
                end else if (held_param == prev_b) begin
                    held_size  = b;
                    parse_mode = PM_PAYLOAD;
                end else begin
                    held_param = b;
                end
            end
            PM_PAYLOAD: begin
                if (prev_b == esc_b && b == sep_b) begin
                    payload_count = '0;
                    parse_mode    = PM_PARAM;
                end else if (held_size != '0 && t_index'(held_size) == payload_count) begin
                    parse_mode    = (b == sep_b) ? PM_PARAM : PM_ERROR;
                    payload_count = '0;
                end else begin
                    payload_count = payload_count + 1'b1;
                    queue_event(EV_PAYLOAD, payload_count, b);
                end
            end
            PM_END: begin
                queue_event(EV_END, '0, '0);
                held_op       = '0;
                held_param    = '0;
                held_size     = '0;
                payload_count = '0;
                parse_mode    = PM_WAIT;
            end
            PM_ERROR: begin
                queue_event(EV_ERROR, '0, '0);
                parse_mode = PM_END;
            end
            default: ;
        endcase
        prev_b = b;
    endfunction

    function string describe(t_parser_event ev);
        return $sformatf("kind %0d op %02h param %02h size %02h index %0d data %02h",
                         ev.kind, ev.op_code, ev.param_id, ev.param_size,
                         ev.byte_index, ev.payload_byte);
    endfunction

    task report(string what);
        if (errors < 100) $display("%0t: %s", $time, what);
        errors++;
    endtask

    // accepted output word
    task check_event(t_parser_event got);
        t_parser_event want;
        bit            bad;
        seen++;
        if (due_events.size() == 0) begin
            report($sformatf("word %0d unexpected: %s", seen, describe(got)));
            return;
        end
        want = due_events.pop_front();
        bad  = (got.kind !== want.kind) || (got.op_code !== want.op_code)
            || (got.param_id !== want.param_id) || (got.param_size !== want.param_size)
            || (got.byte_index !== want.byte_index)
            || (got.payload_byte !== want.payload_byte);
        if (bad)
            report($sformatf("word %0d: got %s, want %s", seen, describe(got), describe(want)));
    endtask
endclass

module tb_framed_command_stream_parser_unit;

    localparam int WATCHDOG_LIMIT = 2000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    t_byte                i_cfg_wdata;

    fcsp_rx_if rx_ch();
    fcsp_ev_if ev_ch();

    frame_event_tracker tracker = new();

    int tx_idle_pct  = 0;
    int rx_idle_pct  = 0;
    int words_sent   = 0;
    int stall_cycles = 0;

    logic [CFG_IDX_W-1:0] reg_order [4] = '{CFG_START, CFG_SEPARATOR, CFG_END, CFG_ESCAPE};

    // two frames at reset framing bytes: op equal to held param, sized and
    // unsized payloads, escape exit, end marker, then a size overrun error
    t_byte directed_bytes [24] = '{
        8'h00, 8'hFF, START_RST, 8'h00, 8'h02, 8'hFF, 8'h00, SEPARATOR_RST,
        8'h05, 8'h00, ESCAPE_RST, 8'h01, ESCAPE_RST, SEPARATOR_RST, END_RST, 8'hAA,
        START_RST, 8'h80, 8'h07, 8'h01, 8'h55, 8'h99, 8'h00, 8'h00
    };

    framed_command_stream_parser_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rx        (rx_ch),
        .o_ev        (ev_ch)
    );

    always #6 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        ev_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        t_parser_event got;
        if (i_rst_n && ev_ch.valid && ev_ch.ready) begin
            got.kind         = ev_ch.event_kind;
            got.op_code      = ev_ch.op_code;
            got.param_id     = ev_ch.param_id;
            got.param_size   = ev_ch.param_size;
            got.byte_index   = ev_ch.byte_index;
            got.payload_byte = ev_ch.payload_byte;
            tracker.check_event(got);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (rx_ch.valid && rx_ch.ready) || (ev_ch.valid && ev_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic t_byte byte_other_than(t_byte avoid);
        t_byte b;
        do b = t_byte'($urandom); while (b == avoid);
        return b;
    endfunction

    // called and returns just after a falling edge
    task automatic push_byte(input t_byte b);
        while ($urandom_range(99) < tx_idle_pct) begin
            rx_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        @(posedge i_clk);
        while (!rx_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        if (tracker.parse_mode != PM_WAIT || b == tracker.start_b) words_sent++;
        tracker.take_byte(b);
    endtask

    task automatic wait_for_quiet(int settle);
        rx_ch.valid <= 1'b0;
        while (tracker.pending() != 0) @(negedge i_clk);
        repeat (settle) @(negedge i_clk);
    endtask

    // close whatever frame is open
    task automatic steer_to_wait();
        for (int k = 0; k < 32 && tracker.parse_mode != PM_WAIT; k++) begin
            case (tracker.parse_mode)
                PM_PARAM:
                    push_byte(tracker.prev_b == tracker.sep_b ? tracker.end_b : tracker.sep_b);
                PM_PAYLOAD:
                    push_byte(tracker.prev_b == tracker.esc_b ? tracker.sep_b : tracker.esc_b);
                default:
                    push_byte(t_byte'($urandom));
            endcase
        end
    endtask

    task automatic send_frame();
        int    n_params;
        int    r;
        int    fate;
        t_byte sz;
        n_params = $urandom_range(1, 3);
        push_byte(tracker.start_b);
        push_byte(t_byte'($urandom));
        for (int p = 0; p < n_params; p++) begin
            push_byte(byte_other_than(tracker.end_b));
            r = $urandom_range(99);
            if (r < 25)      sz = '0;
            else if (r < 28) sz = 8'hFF;
            else             sz = t_byte'($urandom_range(1, 6));
            push_byte(sz);
            fate = $urandom_range(99);
            if (sz == '0) begin
                repeat ($urandom_range(0, 8)) push_byte(byte_other_than(tracker.esc_b));
                push_byte(tracker.esc_b);
                push_byte(tracker.sep_b);
            end else if (fate < 10) begin
                repeat ($urandom_range(0, sz - 1)) push_byte(byte_other_than(tracker.esc_b));
                push_byte(tracker.esc_b);
                push_byte(tracker.sep_b);
            end else begin
                repeat (sz) push_byte(byte_other_than(tracker.esc_b));
                if (fate < 22) begin
                    // overrun: error word, then end word
                    push_byte(byte_other_than(tracker.sep_b));
                    push_byte(t_byte'($urandom));
                    push_byte(t_byte'($urandom));
                    return;
                end
                push_byte(tracker.sep_b);
            end
        end
        if ($urandom_range(1)) push_byte(tracker.sep_b);
        push_byte(tracker.end_b);
        push_byte(t_byte'($urandom));
    endtask

    task automatic send_random_words(int target);
        int goal;
        int r;
        goal = words_sent + target;
        while (words_sent < goal) begin
            steer_to_wait();
            r = $urandom_range(99);
            if (r < 80) begin
                send_frame();
            end else if (r < 90) begin
                repeat ($urandom_range(1, 6)) push_byte(t_byte'($urandom));
            end else begin
                push_byte(tracker.start_b);
                repeat ($urandom_range(1, 8)) push_byte(t_byte'($urandom));
            end
        end
    endtask

    initial begin
        t_cfg  cfg;
        t_byte wdata;
        rx_ch.valid   = 1'b0;
        rx_ch.rx_byte = '0;
        ev_ch.ready   = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = CFG_START;
        i_cfg_wdata   = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int seg = 0; seg < 6; seg++) begin
            tx_idle_pct = (seg < 2) ? 14 : (seg < 4) ? 62 : 0;
            rx_idle_pct = (seg < 2) ? 62 : (seg < 4) ? 14 : 0;
            if (seg == 0) begin
                foreach (directed_bytes[k]) push_byte(directed_bytes[k]);
            end else begin
                case (seg)
                    1:       cfg = '{8'h00, 8'hFF, 8'h00, 8'hFF};
                    2:       cfg = '{8'hFF, 8'h00, 8'hFF, 8'h00};
                    5:       cfg = '{START_RST, SEPARATOR_RST, END_RST, ESCAPE_RST};
                    default: cfg = t_cfg'($urandom);
                endcase
                wait_for_quiet(4);
                for (int k = 0; k < 4; k++) begin
                    case (reg_order[k])
                        CFG_START:     wdata = cfg.start_byte;
                        CFG_SEPARATOR: wdata = cfg.separator_byte;
                        CFG_END:       wdata = cfg.end_byte;
                        default:       wdata = cfg.escape_byte;
                    endcase
                    i_cfg_we    <= 1'b1;
                    i_cfg_idx   <= reg_order[k];
                    i_cfg_wdata <= wdata;
                    @(negedge i_clk);
                    tracker.set_reg(reg_order[k], wdata);
                end
                i_cfg_we <= 1'b0;
            end
            send_random_words(130);
        end

        wait_for_quiet(8);
        if (tracker.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
